// ----- hdl/cffp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffp_pkg
// Shared types and codes of the camera frame field parser: parser phases,
// configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package cffp_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_cfg_idx;

    // parser phases
    localparam t_phase PH_WAIT_FIRST  = 2'd0;
    localparam t_phase PH_WAIT_SECOND = 2'd1;
    localparam t_phase PH_STORE       = 2'd2;
    localparam t_phase PH_DROP        = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx CFG_FIRST_HEADER  = 2'd0;
    localparam t_cfg_idx CFG_SECOND_HEADER = 2'd1;
    localparam t_cfg_idx CFG_END_MARKER    = 2'd2;

    // register reset values
    localparam t_byte RST_FIRST_HEADER  = 8'h2C;
    localparam t_byte RST_SECOND_HEADER = 8'h12;
    localparam t_byte RST_END_MARKER    = 8'h5B;

    // fewest stored bytes that give a full set of four fields
    localparam int MIN_FRAME = 5;

    // number of fields carried by one result
    localparam int NUM_FIELDS = 4;

endpackage

// ----- hdl/camera_frame_field_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_frame_field_parser_unit
// Header-framed serial byte parser that extracts four signed fields per frame.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and accepts a byte in every clock cycle
// while the result register is free or being emptied; a result appears in the
// cycle after the byte that ends its frame. A frame starts with the
// first_header byte followed by the second_header byte (both count as stored
// bytes) and ends when FRAME_DEPTH bytes are stored or the end_marker byte
// arrives. The result carries the four stored bytes just before the last
// one, as signed values; frames with fewer than five stored bytes give no
// result. The byte after a frame is always dropped. Only a four-byte history
// and a byte count are kept, so there is no clearing pass after reset. The
// rate is set by the single registered pass from the byte register to the
// result register; the input stalls only while a held result is stalled.
// ----------------------------------------------------------------------------
module camera_frame_field_parser_unit #(
    parameter int FRAME_DEPTH = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  cffp_pkg::t_cfg_idx      i_cfg_idx,
    input  cffp_pkg::t_byte         i_cfg_data,
    // byte input
    input  logic                    i_valid,
    output logic                    o_stall,
    input  cffp_pkg::t_byte         i_rx_byte,
    // field output
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [7:0]       o_center_x,
    output logic signed [7:0]       o_center_y,
    output logic signed [7:0]       o_box_width,
    output logic signed [7:0]       o_box_height
);
    import cffp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

    // configuration registers
    t_byte r_first_header;
    t_byte r_second_header;
    t_byte r_end_marker;

    // parser state
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    t_byte            r_hist [NUM_FIELDS];   // index 0 is the newest stored byte
    logic             hist_shift;

    // result register
    logic             r_out_valid, n_out_valid;
    logic             emit;
    t_byte            r_field [NUM_FIELDS];

    logic             in_take;
    logic             out_take;
    logic [CNT_W-1:0] count_inc;

    // handshake
    assign out_take = r_out_valid & ~i_stall;
    assign o_stall  = r_out_valid & i_stall;
    assign in_take  = i_valid & ~o_stall;
    assign count_inc = r_count + CNT_W'(1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_header  <= RST_FIRST_HEADER;
            r_second_header <= RST_SECOND_HEADER;
            r_end_marker    <= RST_END_MARKER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_HEADER:  r_first_header  <= i_cfg_data;
                CFG_SECOND_HEADER: r_second_header <= i_cfg_data;
                CFG_END_MARKER:    r_end_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase, count and emit decision for one beat
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        hist_shift = 1'b0;
        emit       = 1'b0;
        if (in_take) begin
            case (r_phase)
                PH_WAIT_FIRST: begin
                    if (i_rx_byte == r_first_header) begin
                        n_phase    = PH_WAIT_SECOND;
                        n_count    = CNT_W'(1);
                        hist_shift = 1'b1;
                    end else begin
                        n_count = '0;
                    end
                end
                PH_WAIT_SECOND: begin
                    if (i_rx_byte == r_second_header) begin
                        n_phase    = PH_STORE;
                        n_count    = count_inc;
                        hist_shift = 1'b1;
                    end else begin
                        n_phase = PH_WAIT_FIRST;
                        n_count = '0;
                    end
                end
                PH_STORE: begin
                    n_count    = count_inc;
                    hist_shift = 1'b1;
                    if (count_inc >= CNT_W'(FRAME_DEPTH) || i_rx_byte == r_end_marker) begin
                        n_phase = PH_DROP;
                        emit    = (count_inc >= CNT_W'(MIN_FRAME));
                    end
                end
                default: begin
                    n_phase = PH_WAIT_FIRST;
                    n_count = '0;
                end
            endcase
        end
    end

    // result valid: set by an emitting beat, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT_FIRST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // history of the last stored bytes
    always_ff @(posedge i_clk) begin
        if (hist_shift) begin
            r_hist[0] <= i_rx_byte;
            for (int k = 1; k < NUM_FIELDS; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // result fields, oldest history byte first
    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_field[k] <= r_hist[NUM_FIELDS-1-k];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_center_x   = signed'(r_field[0]);
    assign o_center_y   = signed'(r_field[1]);
    assign o_box_width  = signed'(r_field[2]);
    assign o_box_height = signed'(r_field[3]);

endmodule

// ----- hdl/cffp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffp_checker
// Port-level checks of the camera frame field parser, bound to the top level.
// ----------------------------------------------------------------------------
module cffp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [7:0]  o_center_x,
    input logic signed [7:0]  o_center_y,
    input logic signed [7:0]  o_box_width,
    input logic signed [7:0]  o_box_height
);

    // a stalled result beat holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_center_x) && $stable(o_center_y)
            && $stable(o_box_width) && $stable(o_box_height))
        else $error("stalled result beat changed");

    // input stalls only behind a held, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a new result follows an accepted byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("result without an accepted byte");

    // a taken result without a new byte leaves the output empty
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !(i_valid && !o_stall) |=> !o_valid)
        else $error("result repeated");

endmodule

bind camera_frame_field_parser_unit cffp_checker u_cffp_checker (.*);
